@@ hdl/mi3_pkg.sv @@
package mi3_pkg;

    localparam int unsigned N_ELEM   = 9;
    localparam int unsigned N_PROD   = 18;
    localparam int unsigned N_DET    = 3;
    localparam int unsigned DIV_BITS = 4;

    localparam logic [31:0] QNAN    = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG = 31'h7F80_0000;
    // The dividend 1.0 aligned to the first quotient bit.
    localparam logic [25:0] ONE_REM = 26'h080_0000;
    // Cofactors that enter the adjugate with a minus sign.
    localparam logic [8:0]  NEG_MASK = 9'h0AA;

    // Operand pairs of the 18 products: cofactor k is product 2k minus product 2k+1.
    localparam logic [3:0] OPND [0:35] = '{
        4'd4, 4'd8, 4'd7, 4'd5,
        4'd1, 4'd8, 4'd7, 4'd2,
        4'd1, 4'd5, 4'd4, 4'd2,
        4'd3, 4'd8, 4'd6, 4'd5,
        4'd0, 4'd8, 4'd6, 4'd2,
        4'd0, 4'd5, 4'd3, 4'd2,
        4'd3, 4'd7, 4'd6, 4'd4,
        4'd0, 4'd7, 4'd6, 4'd1,
        4'd0, 4'd4, 4'd3, 4'd1
    };

    typedef struct packed {
        logic              sgn;
        logic              nan;
        logic              inf;
        logic              zero;
        logic signed [10:0] ex;
        logic [23:0]       man;
    } t_unp;

    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic              sgn;
        logic signed [10:0] ex;
        logic [23:0]       ma;
        logic [23:0]       mb;
    } t_mpre;

    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic              sgn;
        logic signed [10:0] ex;
        logic [47:0]       prod;
    } t_mprd;

    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic              sgn;
        logic signed [10:0] ex;
        logic [27:0]       sum;
    } t_apre;

    typedef struct packed {
        logic              spec;
        logic [31:0]       sval;
        logic              sgn;
        logic signed [10:0] ex;
        logic [23:0]       man;
        logic [25:0]       rem;
        logic [27:0]       q;
    } t_dv;

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd28;
        hit = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 5'(27 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] fneg(input logic [31:0] x);
        return {~x[31], x[30:0]};
    endfunction

    function automatic t_unp unpack(input logic [31:0] x);
        t_unp       u;
        logic [4:0] lz;
        u.sgn  = x[31];
        u.nan  = (&x[30:23]) && (|x[22:0]);
        u.inf  = (&x[30:23]) && !(|x[22:0]);
        u.zero = !(|x[30:0]);
        lz     = lzc28({1'b0, x[22:0], 4'hF});
        if (|x[30:23]) begin
            u.man = {1'b1, x[22:0]};
            u.ex  = $signed({3'b000, x[30:23]}) - 11'sd127;
        end else begin
            u.man = {1'b0, x[22:0]} << lz;
            u.ex  = -11'sd126 - $signed({6'b000000, lz});
        end
        return u;
    endfunction

    // The significand carries its leading one at bit 26; bit 0 is sticky.
    function automatic logic [31:0] round_pack(input logic sgn, input logic signed [10:0] ex,
                                               input logic [26:0] sig);
        logic signed [11:0] be;
        logic [4:0]         sh;
        logic [26:0]        s;
        logic [30:0]        fld;
        logic               inc;
        logic [31:0]        res;
        be = $signed({ex[10], ex}) + 12'sd127;
        s  = sig;
        sh = 5'd0;
        if (be <= 12'sd0) begin
            sh = (be < -12'sd26) ? 5'd27 : 5'(12'sd1 - be);
            s  = (sig >> sh) | {26'd0, |(sig & ~({27{1'b1}} << sh))};
            be = 12'sd0;
        end
        fld = {be[7:0], s[25:3]};
        inc = s[2] & ((|s[1:0]) | s[3]);
        res = {sgn, fld + 31'(inc)};
        if (be >= 12'sd255) begin
            res = {sgn, INF_MAG};
        end
        return res;
    endfunction

    function automatic t_mpre mul_a(input logic [31:0] a, input logic [31:0] b);
        t_unp  ua;
        t_unp  ub;
        t_mpre p;
        ua     = unpack(a);
        ub     = unpack(b);
        p.sgn  = a[31] ^ b[31];
        p.ex   = ua.ex + ub.ex;
        p.ma   = ua.man;
        p.mb   = ub.man;
        p.spec = 1'b1;
        if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
            p.sval = QNAN;
        end else if (ua.inf || ub.inf) begin
            p.sval = {p.sgn, INF_MAG};
        end else if (ua.zero || ub.zero) begin
            p.sval = {p.sgn, 31'd0};
        end else begin
            p.spec = 1'b0;
            p.sval = QNAN;
        end
        return p;
    endfunction

    function automatic t_mprd mul_b(input t_mpre p);
        t_mprd r;
        r.spec = p.spec;
        r.sval = p.sval;
        r.sgn  = p.sgn;
        r.ex   = p.ex;
        r.prod = p.ma * p.mb;
        return r;
    endfunction

    function automatic logic [31:0] mul_c(input t_mprd r);
        logic [31:0] res;
        if (r.spec) begin
            res = r.sval;
        end else if (r.prod[47]) begin
            res = round_pack(r.sgn, r.ex + 11'sd1, {r.prod[47:22], |r.prod[21:0]});
        end else begin
            res = round_pack(r.sgn, r.ex, {r.prod[46:21], |r.prod[20:0]});
        end
        return res;
    endfunction

    function automatic t_apre add_a(input logic [31:0] a, input logic [31:0] b);
        t_apre       p;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [4:0]  sh;
        logic [26:0] mb;
        logic [26:0] ms;
        logic [26:0] msh;
        logic        anan;
        logic        bnan;
        logic        ainf;
        logic        binf;
        anan = (&a[30:23]) && (|a[22:0]);
        bnan = (&b[30:23]) && (|b[22:0]);
        ainf = (&a[30:23]) && !(|a[22:0]);
        binf = (&b[30:23]) && !(|b[22:0]);
        if (b[30:0] > a[30:0]) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        eb  = (|big[30:23]) ? big[30:23] : 8'd1;
        es  = (|sml[30:23]) ? sml[30:23] : 8'd1;
        mb  = {|big[30:23], big[22:0], 3'b000};
        ms  = {|sml[30:23], sml[22:0], 3'b000};
        d   = eb - es;
        sh  = (d > 8'd27) ? 5'd27 : d[4:0];
        msh = (ms >> sh) | {26'd0, |(ms & ~({27{1'b1}} << sh))};
        if (big[31] == sml[31]) begin
            p.sum = {1'b0, mb} + {1'b0, msh};
        end else begin
            p.sum = {1'b0, mb} - {1'b0, msh};
        end
        p.sgn  = big[31];
        p.ex   = $signed({3'b000, eb}) - 11'sd127;
        p.spec = 1'b1;
        if (anan || bnan || (ainf && binf && (a[31] != b[31]))) begin
            p.sval = QNAN;
        end else if (ainf) begin
            p.sval = a;
        end else if (binf) begin
            p.sval = b;
        end else if (!(|a[30:0]) && !(|b[30:0])) begin
            p.sval = {a[31] & b[31], 31'd0};
        end else begin
            p.spec = 1'b0;
            p.sval = QNAN;
        end
        return p;
    endfunction

    function automatic logic [31:0] add_b(input t_apre p);
        logic [4:0]  lz;
        logic [27:0] sh28;
        logic [31:0] res;
        lz   = lzc28(p.sum);
        sh28 = p.sum << (lz - 5'd1);
        if (p.spec) begin
            res = p.sval;
        end else if (!(|p.sum)) begin
            res = 32'd0;
        end else if (p.sum[27]) begin
            res = round_pack(p.sgn, p.ex + 11'sd1, {p.sum[27:2], |p.sum[1:0]});
        end else begin
            res = round_pack(p.sgn, p.ex - $signed({6'b000000, lz}) + 11'sd1, sh28[26:0]);
        end
        return res;
    endfunction

    function automatic t_dv div_init(input logic [31:0] x);
        t_unp u;
        t_dv  d;
        u      = unpack(x);
        d.sgn  = u.sgn;
        d.ex   = -11'sd1 - u.ex;
        d.man  = u.man;
        d.rem  = ONE_REM;
        d.q    = '0;
        d.spec = 1'b1;
        if (u.nan) begin
            d.sval = QNAN;
        end else if (u.inf) begin
            d.sval = {u.sgn, 31'd0};
        end else if (u.zero) begin
            d.sval = {u.sgn, INF_MAG};
        end else begin
            d.spec = 1'b0;
            d.sval = QNAN;
        end
        return d;
    endfunction

    function automatic t_dv div_step(input t_dv din);
        t_dv  d;
        logic bit_q;
        d = din;
        for (int i = 0; i < DIV_BITS; i++) begin
            bit_q = (d.rem >= {2'b00, d.man});
            if (bit_q) begin
                d.rem = d.rem - {2'b00, d.man};
            end
            d.q   = {d.q[26:0], bit_q};
            d.rem = {d.rem[24:0], 1'b0};
        end
        return d;
    endfunction

    function automatic logic [31:0] div_fin(input t_dv d);
        logic [31:0] res;
        if (d.spec) begin
            res = d.sval;
        end else if (d.q[27]) begin
            res = round_pack(d.sgn, d.ex + 11'sd1, {1'b1, 26'd0});
        end else begin
            res = round_pack(d.sgn, d.ex, {d.q[26:1], d.q[0] | (|d.rem)});
        end
        return res;
    endfunction

endpackage

@@ hdl/mi3_ifs.sv @@
interface mi3_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] elem_c0_r0;
    logic [31:0] elem_c0_r1;
    logic [31:0] elem_c0_r2;
    logic [31:0] elem_c1_r0;
    logic [31:0] elem_c1_r1;
    logic [31:0] elem_c1_r2;
    logic [31:0] elem_c2_r0;
    logic [31:0] elem_c2_r1;
    logic [31:0] elem_c2_r2;

    modport source (
        output valid, elem_c0_r0, elem_c0_r1, elem_c0_r2, elem_c1_r0, elem_c1_r1,
               elem_c1_r2, elem_c2_r0, elem_c2_r1, elem_c2_r2,
        input  ready
    );
    modport sink (
        input  valid, elem_c0_r0, elem_c0_r1, elem_c0_r2, elem_c1_r0, elem_c1_r1,
               elem_c1_r2, elem_c2_r0, elem_c2_r1, elem_c2_r2,
        output ready
    );
endinterface

interface mi3_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] inv_c0_r0;
    logic [31:0] inv_c0_r1;
    logic [31:0] inv_c0_r2;
    logic [31:0] inv_c1_r0;
    logic [31:0] inv_c1_r1;
    logic [31:0] inv_c1_r2;
    logic [31:0] inv_c2_r0;
    logic [31:0] inv_c2_r1;
    logic [31:0] inv_c2_r2;
    logic        singular;

    modport source (
        output valid, inv_c0_r0, inv_c0_r1, inv_c0_r2, inv_c1_r0, inv_c1_r1,
               inv_c1_r2, inv_c2_r0, inv_c2_r1, inv_c2_r2, singular,
        input  ready
    );
    modport sink (
        input  valid, inv_c0_r0, inv_c0_r1, inv_c0_r2, inv_c1_r0, inv_c1_r1,
               inv_c1_r2, inv_c2_r0, inv_c2_r1, inv_c2_r2, singular,
        output ready
    );
endinterface

@@ hdl/matrix_inverse_3x3.sv @@
// Channel  Direction  Contents
// i_req    in         one request: nine binary32 matrix elements, column by row
// o_rsp    out        one request: nine binary32 inverse elements and the singular flag
//
// One request enters per cycle while the output is not held.
// The reciprocal divider has seven stages of four quotient bits.
// Reset clears only the stage valid bits; the datapath holds no state between requests.
// When the output is held, the whole pipeline stops and i_req.ready falls in the same cycle.

module matrix_inverse_3x3 (
    input logic i_clk,
    input logic i_rst_n,
    mi3_req_if.sink   i_req,
    mi3_rsp_if.source o_rsp
);
    import mi3_pkg::*;

    logic        w_adv;
    logic [31:0] w_m [N_ELEM];

    logic [24:1] r_vld;
    logic [24:13] r_sng;

    t_mpre       r_ma1 [N_PROD];
    t_mprd       r_mb2 [N_PROD];
    logic [31:0] r_p3  [N_PROD];
    logic [2:0][31:0] r_e [1:5];
    t_apre       r_a4  [N_ELEM];
    logic [31:0] r_d5  [N_ELEM];
    logic [8:0][31:0] r_cof [6:21];
    t_mpre       r_ma6 [N_DET];
    t_mprd       r_mb7 [N_DET];
    logic [31:0] r_t8  [N_DET];
    t_apre       r_a9;
    logic [31:0] r_t2  [9:10];
    logic [31:0] r_x10;
    t_apre       r_a11;
    logic [31:0] r_det12;
    t_dv         r_dv  [13:20];
    logic [31:0] r_rcp21;
    t_mpre       r_ma22 [N_ELEM];
    t_mprd       r_mb23 [N_ELEM];
    logic [31:0] r_inv24 [N_ELEM];

    assign w_m[0] = i_req.elem_c0_r0;
    assign w_m[1] = i_req.elem_c0_r1;
    assign w_m[2] = i_req.elem_c0_r2;
    assign w_m[3] = i_req.elem_c1_r0;
    assign w_m[4] = i_req.elem_c1_r1;
    assign w_m[5] = i_req.elem_c1_r2;
    assign w_m[6] = i_req.elem_c2_r0;
    assign w_m[7] = i_req.elem_c2_r1;
    assign w_m[8] = i_req.elem_c2_r2;

    assign w_adv       = !r_vld[24] || o_rsp.ready;
    assign i_req.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[23:1], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < N_PROD; j++) begin
                r_ma1[j] <= mul_a(w_m[OPND[2*j]], w_m[OPND[2*j+1]]);
                r_mb2[j] <= mul_b(r_ma1[j]);
                r_p3[j]  <= mul_c(r_mb2[j]);
            end
            r_e[1] <= {w_m[6], w_m[3], w_m[0]};
            for (int s = 2; s <= 5; s++) begin
                r_e[s] <= r_e[s-1];
            end

            for (int k = 0; k < N_ELEM; k++) begin
                r_a4[k]     <= add_a(r_p3[2*k], fneg(r_p3[2*k+1]));
                r_d5[k]     <= add_b(r_a4[k]);
                r_cof[6][k] <= r_d5[k];
            end
            for (int s = 7; s <= 21; s++) begin
                r_cof[s] <= r_cof[s-1];
            end

            for (int i = 0; i < N_DET; i++) begin
                r_ma6[i] <= mul_a(r_e[5][i], r_d5[i]);
                r_mb7[i] <= mul_b(r_ma6[i]);
                r_t8[i]  <= mul_c(r_mb7[i]);
            end

            r_a9    <= add_a(r_t8[0], fneg(r_t8[1]));
            r_t2[9] <= r_t8[2];
            r_x10   <= add_b(r_a9);
            r_t2[10] <= r_t2[9];
            r_a11   <= add_a(r_x10, r_t2[10]);
            r_det12 <= add_b(r_a11);

            r_dv[13]  <= div_init(r_det12);
            r_sng[13] <= !(|r_det12[30:0]);
            for (int s = 14; s <= 20; s++) begin
                r_dv[s] <= div_step(r_dv[s-1]);
            end
            for (int s = 14; s <= 24; s++) begin
                r_sng[s] <= r_sng[s-1];
            end
            r_rcp21 <= div_fin(r_dv[20]);

            for (int k = 0; k < N_ELEM; k++) begin
                r_ma22[k]  <= mul_a({r_cof[21][k][31] ^ NEG_MASK[k], r_cof[21][k][30:0]},
                                    r_rcp21);
                r_mb23[k]  <= mul_b(r_ma22[k]);
                r_inv24[k] <= mul_c(r_mb23[k]);
            end
        end
    end

    assign o_rsp.valid     = r_vld[24];
    assign o_rsp.inv_c0_r0 = r_inv24[0];
    assign o_rsp.inv_c0_r1 = r_inv24[1];
    assign o_rsp.inv_c0_r2 = r_inv24[2];
    assign o_rsp.inv_c1_r0 = r_inv24[3];
    assign o_rsp.inv_c1_r1 = r_inv24[4];
    assign o_rsp.inv_c1_r2 = r_inv24[5];
    assign o_rsp.inv_c2_r0 = r_inv24[6];
    assign o_rsp.inv_c2_r1 = r_inv24[7];
    assign o_rsp.inv_c2_r2 = r_inv24[8];
    assign o_rsp.singular  = r_sng[24];

    // An accepted request always occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_vld[1])
        else $error("accepted request did not enter the pipeline");

    // A held output freezes every stage.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> $stable(r_vld))
        else $error("pipeline moved while the output was held");

    // A zero determinant must give an infinite reciprocal.
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[21] && r_sng[21] |-> r_rcp21[30:0] == INF_MAG)
        else $error("singular request without infinite reciprocal");

    // The reciprocal of a normalized significand has its leading one in the top two bits.
    a_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[20] && !r_dv[20].spec |-> r_dv[20].q[27] || r_dv[20].q[26])
        else $error("quotient not normalized");

endmodule

@@ tb/mi3_checker.sv @@
`timescale 1ns / 100ps

module mi3_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mi3_req_if   i_req,
    mi3_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import mi3_pkg::*;

    localparam logic [31:0] FLT_ONE = 32'h3F80_0000;
    localparam logic [31:0] FLT_INF = 32'h7F80_0000;

    typedef struct {
        logic [8:0][31:0] inv;
        logic             singular;
    } t_inverse;

    t_inverse inverse_queue[$];
    int       mismatches;

    function automatic real flt_to_real(input logic [31:0] f);
        real v;
        if (f[30:23] == 8'hFF) begin
            v = $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
        end else if (f[30:23] == 8'd0) begin
            v = $itor(f[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
            if (f[31]) begin
                v = -v;
            end
            if (f[22:0] == 23'd0) begin
                v = $bitstoreal({f[31], 63'd0});
            end
        end else begin
            v = $bitstoreal({f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'd0});
        end
        return v;
    endfunction

    // Rounds a double to binary32, nearest even, subnormals kept.
    function automatic logic [31:0] real_to_flt(input real x);
        logic [63:0] d;
        longint      be;
        longint      sh;
        longint      sig;
        longint      m;
        longint      rem;
        longint      half;
        longint      fld;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 52'd0) ? QNAN : {d[63], FLT_INF[30:0]};
        end
        if (d[62:52] == 11'd0) begin
            return {d[63], 31'd0};
        end
        be  = longint'(d[62:52]) - 1023 + 127;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (be >= 1) ? 29 : 30 - be;
        if (sh > 60) begin
            sh = 60;
        end
        m    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && m[0])) begin
            m = m + 1;
        end
        fld = ((be >= 1) ? ((be - 1) << 23) : 0) + m;
        if (fld >= longint'(FLT_INF)) begin
            return {d[63], FLT_INF[30:0]};
        end
        return {d[63], 31'(fld)};
    endfunction

    function automatic logic [31:0] fmul32(input logic [31:0] a, input logic [31:0] b);
        return real_to_flt(flt_to_real(a) * flt_to_real(b));
    endfunction

    function automatic logic [31:0] cofactor(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        return real_to_flt(flt_to_real(fmul32(a, b)) - flt_to_real(fmul32(c, d)));
    endfunction

    function automatic logic [31:0] reciprocal(input logic [31:0] x);
        if (x[30:23] == 8'hFF) begin
            return (x[22:0] != 23'd0) ? QNAN : {x[31], 31'd0};
        end
        if (x[30:0] == 31'd0) begin
            return {x[31], FLT_INF[30:0]};
        end
        return real_to_flt(flt_to_real(FLT_ONE) / flt_to_real(x));
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] x);
        return (x[30:23] == 8'hFF && x[22:0] != 23'd0) ? QNAN : x;
    endfunction

    // m[c*3+r] holds column c, row r.
    function automatic t_inverse predict_inverse(input logic [8:0][31:0] m);
        t_inverse        res;
        logic [8:0][31:0] adj;
        logic [31:0]     k01;
        logic [31:0]     det;
        logic [31:0]     rcp;
        adj[0] = cofactor(m[4], m[8], m[7], m[5]);
        k01    = cofactor(m[1], m[8], m[7], m[2]);
        adj[2] = cofactor(m[1], m[5], m[4], m[2]);
        det = real_to_flt(flt_to_real(fmul32(m[0], adj[0])) - flt_to_real(fmul32(m[3], k01)));
        det = real_to_flt(flt_to_real(det) + flt_to_real(fmul32(m[6], adj[2])));
        rcp = reciprocal(det);
        adj[3] = fneg(cofactor(m[3], m[8], m[6], m[5]));
        adj[6] = cofactor(m[3], m[7], m[6], m[4]);
        adj[1] = fneg(k01);
        adj[4] = cofactor(m[0], m[8], m[6], m[2]);
        adj[7] = fneg(cofactor(m[0], m[7], m[6], m[1]));
        adj[5] = fneg(cofactor(m[0], m[5], m[3], m[2]));
        adj[8] = cofactor(m[0], m[4], m[3], m[1]);
        for (int i = 0; i < 9; i++) begin
            res.inv[i] = canon(fmul32(adj[i], rcp));
        end
        res.singular = (det[30:0] == 31'd0);
        return res;
    endfunction

    assign o_pending = inverse_queue.size();

    always @(posedge i_clk) begin
        logic [8:0][31:0] m;
        logic [8:0][31:0] got;
        t_inverse         want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            mismatches = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                m = {i_req.elem_c2_r2, i_req.elem_c2_r1, i_req.elem_c2_r0,
                     i_req.elem_c1_r2, i_req.elem_c1_r1, i_req.elem_c1_r0,
                     i_req.elem_c0_r2, i_req.elem_c0_r1, i_req.elem_c0_r0};
                inverse_queue.push_back(predict_inverse(m));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.inv_c2_r2, i_rsp.inv_c2_r1, i_rsp.inv_c2_r0,
                       i_rsp.inv_c1_r2, i_rsp.inv_c1_r1, i_rsp.inv_c1_r0,
                       i_rsp.inv_c0_r2, i_rsp.inv_c0_r1, i_rsp.inv_c0_r0};
                if (inverse_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected response at %0t", $time);
                    end
                end else begin
                    want = inverse_queue.pop_front();
                    if (want.inv != got || want.singular != i_rsp.singular) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t: expected %h sing %b, got %h sing %b",
                                     $time, want.inv, want.singular, got, i_rsp.singular);
                        end
                    end
                end
            end
            o_fail_count <= mismatches;
        end
    end
endmodule

@@ tb/matrix_inverse_3x3_tb.sv @@
`timescale 1ns / 100ps

module matrix_inverse_3x3_tb;
    localparam int MAX_CYCLES = 300000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    logic hold_req;
    logic hold_busy;

    mi3_req_if req_ch ();
    mi3_rsp_if rsp_ch ();

    matrix_inverse_3x3 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mi3_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > MAX_CYCLES) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_elem();
        logic [31:0] v;
        case ($urandom_range(0, 11))
            0: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0000_0000;
                    1: v = 32'h8000_0000;
                    2: v = 32'h7F80_0000;
                    3: v = 32'hFF80_0000;
                    4: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom | 1)};
                    default: v = 32'h7F7F_FFFF;
                endcase
            end
            1: v = $urandom;
            2: v = {1'($urandom), 8'd0, 23'($urandom)};
            3, 4: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0000_0000;
                    1: v = 32'h3F80_0000;
                    2: v = 32'h4000_0000;
                    3: v = 32'hBF80_0000;
                    4: v = 32'hC000_0000;
                    default: v = 32'h4040_0000;
                endcase
            end
            5: v = {1'($urandom), 8'($urandom_range(1, 254)), 23'($urandom)};
            default: v = {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
        endcase
        return v;
    endfunction

    task automatic send_matrix(input logic [8:0][31:0] m);
        req_ch.valid      = 1'b1;
        req_ch.elem_c0_r0 = m[0];
        req_ch.elem_c0_r1 = m[1];
        req_ch.elem_c0_r2 = m[2];
        req_ch.elem_c1_r0 = m[3];
        req_ch.elem_c1_r1 = m[4];
        req_ch.elem_c1_r2 = m[5];
        req_ch.elem_c2_r0 = m[6];
        req_ch.elem_c2_r1 = m[7];
        req_ch.elem_c2_r2 = m[8];
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        req_ch.valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic send_same(input logic [31:0] a);
        send_matrix({9{a}});
    endtask

    initial begin
        int stall_mode;
        int hold_left;
        rsp_ch.ready = 1'b0;
        hold_busy    = 1'b0;
        stall_mode   = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_busy) begin
                hold_busy = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end else begin
                hold_busy = 1'b0;
                if ($urandom_range(0, 63) == 0) begin
                    stall_mode = $urandom_range(0, 3);
                end
                case (stall_mode)
                    0: rsp_ch.ready = 1'b1;
                    1: rsp_ch.ready = ($urandom_range(0, 1) == 0);
                    2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        logic [8:0][31:0] m;
        int burst;
        req_ch.valid      = 1'b0;
        req_ch.elem_c0_r0 = '0;
        req_ch.elem_c0_r1 = '0;
        req_ch.elem_c0_r2 = '0;
        req_ch.elem_c1_r0 = '0;
        req_ch.elem_c1_r1 = '0;
        req_ch.elem_c1_r2 = '0;
        req_ch.elem_c2_r0 = '0;
        req_ch.elem_c2_r1 = '0;
        req_ch.elem_c2_r2 = '0;
        hold_req          = 1'b0;
        i_rst_n           = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_matrix({32'h3F80_0000, 96'd0, 32'h3F80_0000, 96'd0, 32'h3F80_0000});
        send_same(32'h0000_0000);
        send_same(32'h8000_0000);
        send_same(32'h3F80_0000);
        send_same(32'h7F80_0000);
        send_same(32'hFF80_0000);
        send_same(32'h7FC0_0001);
        send_same(32'hFFFF_FFFF);
        send_same(32'h0000_0001);
        send_same(32'h807F_FFFF);
        send_same(32'h7F7F_FFFF);
        send_matrix({32'h7F7F_FFFF, 96'd0, 32'h7F7F_FFFF, 96'd0, 32'h7F7F_FFFF});
        send_matrix({32'h0080_0000, 96'd0, 32'h0080_0000, 96'd0, 32'h0080_0000});
        send_matrix({32'h4040_0000, 32'h4000_0000, 32'h3F80_0000, 32'hC000_0000,
                     32'h3F80_0000, 32'h4040_0000, 32'h3F80_0000, 32'hBF80_0000,
                     32'h4000_0000});
        send_matrix({32'h4000_0000, 32'h3F80_0000, 32'h0000_0000, 32'h4000_0000,
                     32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000,
                     32'h3F80_0000});
        send_matrix({32'h7F80_0000, 96'd0, 32'h3F80_0000, 96'd0, 32'h3F80_0000});
        send_matrix({32'h4000_0000, 96'd0, 32'hBF80_0000, 96'd0, 32'h8000_0000});

        for (int n = 0; n < 1550; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++) begin
                for (int i = 0; i < 9; i++) begin
                    m[i] = rand_elem();
                end
                send_matrix(m);
                n++;
            end
            if (n > 500 && n <= 540 && !hold_busy) begin
                req_ch.valid = 1'b0;
                hold_req     = 1'b1;
                wait (hold_busy);
                hold_req = 1'b0;
            end
            if (n > 1000 && n <= 1040) begin
                req_ch.valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 2) != 0) begin
                idle_cycles($urandom_range(1, 12));
            end
        end
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ matrix_inverse_3x3.f @@
hdl/mi3_pkg.sv
hdl/mi3_ifs.sv
hdl/matrix_inverse_3x3.sv
tb/mi3_checker.sv
tb/matrix_inverse_3x3_tb.sv
